// ===== src/cpr_pkg.sv =====
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared widths, codes, word types and control structs for the clock page
// replacement block.
// ----------------------------------------------------------------------------
package cpr_pkg;

	localparam int PAGE_BITS  = 20;
	localparam int WS_SLOTS   = 16;
	localparam int SLOT_W     = 4;
	localparam int STATUS_W   = 3;
	localparam int WS_SIZE_W  = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [STATUS_W-1:0] STATUS_PLACED   = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_REPLACED = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_HIT      = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_MISS     = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_RESIDENT = 3'd4;

	localparam logic MODE_ACCESS = 1'b0;
	localparam logic MODE_FAULT  = 1'b1;

	localparam logic ALG_CLOCK    = 1'b0;
	localparam logic ALG_MODIFIED = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ALGORITHM = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WS_SIZE   = 1'b1;

	localparam logic [WS_SIZE_W-1:0] WS_SIZE_RST = 5'd16;

	typedef struct packed {
		logic                 mode;
		logic [PAGE_BITS-1:0] page_number;
		logic                 is_write;
	} in_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [SLOT_W-1:0]    slot;
		logic [PAGE_BITS-1:0] victim_page;
		logic                 writeback;
	} out_word_t;

	typedef enum logic [2:0] {
		OP_HIT,
		OP_MISS,
		OP_RESIDENT,
		OP_PLACE,
		OP_REPLACE
	} op_t;

	typedef struct packed {
		logic lookup_start;
		logic lookup_next;
		logic scan_start;
		logic scan_step;
		logic commit;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic match;
		logic lookup_last;
		logic can_place;
		logic victim_found;
		logic mode;
	} sts_t;

endpackage

// ===== src/cpr_dp.sv =====
// ----------------------------------------------------------------------------
// cpr_dp
// Datapath: configuration registers, page memory, used and modified bits,
// lookup index, clock hand, victim scan pointer and output word register.
// ----------------------------------------------------------------------------
module cpr_dp #(
	parameter int WS_SLOTS = cpr_pkg::WS_SLOTS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cpr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cpr_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  cpr_pkg::in_word_t                   in_word,
	input  cpr_pkg::cmd_t                       cmd,
	output cpr_pkg::sts_t                       sts,
	output cpr_pkg::out_word_t                  out_word
);

	localparam int IW = $clog2(WS_SLOTS);
	localparam int FW = $clog2(WS_SLOTS + 1);
	localparam int CW = (FW > cpr_pkg::WS_SIZE_W) ? FW : cpr_pkg::WS_SIZE_W;
	localparam int PW = cpr_pkg::PAGE_BITS;
	localparam int SW = cpr_pkg::SLOT_W;
	localparam logic [CW-1:0] SLOTS_C = CW'(WS_SLOTS);
	localparam logic [FW-1:0] SLOTS_F = FW'(WS_SLOTS);

	logic                           alg_q;
	logic [cpr_pkg::WS_SIZE_W-1:0]  ws_size_q;
	logic [PW-1:0]                  page_q;
	logic                           mode_q;
	logic                           wr_q;
	logic [PW-1:0]                  page_mem_q [WS_SLOTS];
	logic [PW-1:0]                  rd_data_q;
	logic [WS_SLOTS-1:0]            used_q;
	logic [WS_SLOTS-1:0]            dirty_q;
	logic [IW-1:0]                  hand_q;
	logic [FW-1:0]                  fill_q;
	logic [IW-1:0]                  idx_q;
	logic [IW-1:0]                  ptr_q;
	logic [IW-1:0]                  cnt_q;
	logic                           phase_q;

	logic [CW-1:0]      ws_ext;
	logic [CW-1:0]      eff_size;
	logic [FW-1:0]      idx_inc;
	logic [FW-1:0]      ptr_inc;
	logic [IW-1:0]      ptr_nxt;
	logic [IW-1:0]      start;
	logic               cnt_last;
	logic [IW-1:0]      rd_addr;
	logic [IW-1:0]      wr_addr;
	logic               mem_we;
	cpr_pkg::out_word_t out_d;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q     <= cpr_pkg::ALG_CLOCK;
			ws_size_q <= cpr_pkg::WS_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cpr_pkg::CFG_ALGORITHM: alg_q     <= cfg_data[0];
				cpr_pkg::CFG_WS_SIZE:   ws_size_q <= cfg_data[cpr_pkg::WS_SIZE_W-1:0];
			endcase
		end
	end

	// size clamp, lookup status and scan status
	always_comb begin
		ws_ext = CW'(ws_size_q);
		if (ws_size_q == '0) begin
			eff_size = CW'(1);
		end else if (ws_ext > SLOTS_C) begin
			eff_size = SLOTS_C;
		end else begin
			eff_size = ws_ext;
		end
		idx_inc  = FW'(idx_q) + FW'(1);
		ptr_inc  = FW'(ptr_q) + FW'(1);
		ptr_nxt  = (ptr_inc < fill_q) ? ptr_inc[IW-1:0] : '0;
		start    = (FW'(hand_q) < fill_q) ? hand_q : '0;
		cnt_last = (FW'(cnt_q) + FW'(1)) == fill_q;

		sts.match        = (FW'(idx_q) < fill_q) && (rd_data_q == page_q);
		sts.lookup_last  = idx_inc >= fill_q;
		sts.can_place    = CW'(fill_q) < eff_size;
		sts.victim_found = phase_q ? !used_q[ptr_q] : (!used_q[ptr_q] && !dirty_q[ptr_q]);
		sts.mode         = mode_q;
	end

	// page memory, one read and one write port
	always_comb begin
		if (cmd.lookup_start) begin
			rd_addr = '0;
		end else if (cmd.lookup_next) begin
			rd_addr = idx_inc[IW-1:0];
		end else begin
			rd_addr = ptr_q;
		end
		mem_we  = cmd.commit && (cmd.op == cpr_pkg::OP_PLACE || cmd.op == cpr_pkg::OP_REPLACE);
		wr_addr = (cmd.op == cpr_pkg::OP_PLACE) ? fill_q[IW-1:0] : ptr_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			page_mem_q[wr_addr] <= page_q;
		end
		rd_data_q <= page_mem_q[rd_addr];
	end

	// latched input word
	always_ff @(posedge clk) begin
		if (cmd.lookup_start) begin
			page_q <= in_word.page_number;
			mode_q <= in_word.mode;
			wr_q   <= in_word.is_write;
		end
	end

	// lookup index and scan pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			ptr_q   <= '0;
			cnt_q   <= '0;
			phase_q <= 1'b0;
		end else begin
			if (cmd.lookup_start) begin
				idx_q <= '0;
			end else if (cmd.lookup_next) begin
				idx_q <= idx_inc[IW-1:0];
			end
			if (cmd.scan_start) begin
				ptr_q   <= start;
				cnt_q   <= '0;
				phase_q <= (alg_q == cpr_pkg::ALG_CLOCK);
			end else if (cmd.scan_step) begin
				ptr_q <= ptr_nxt;
				if (cnt_last) begin
					cnt_q   <= '0;
					phase_q <= phase_q ? (alg_q == cpr_pkg::ALG_CLOCK) : 1'b1;
				end else begin
					cnt_q <= cnt_q + IW'(1);
				end
			end
		end
	end

	// slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			dirty_q <= '0;
			hand_q  <= '0;
			fill_q  <= '0;
		end else begin
			if (cmd.scan_step && phase_q) begin
				used_q[ptr_q] <= 1'b0;
			end
			if (cmd.commit) begin
				case (cmd.op)
					cpr_pkg::OP_HIT: begin
						used_q[idx_q] <= 1'b1;
						if (wr_q) begin
							dirty_q[idx_q] <= 1'b1;
						end
					end
					cpr_pkg::OP_PLACE: begin
						used_q[fill_q[IW-1:0]]  <= 1'b0;
						dirty_q[fill_q[IW-1:0]] <= 1'b0;
						fill_q                  <= fill_q + FW'(1);
					end
					cpr_pkg::OP_REPLACE: begin
						used_q[ptr_q]  <= 1'b0;
						dirty_q[ptr_q] <= 1'b0;
						hand_q         <= ptr_nxt;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// result word
	always_comb begin
		out_d = '0;
		case (cmd.op)
			cpr_pkg::OP_HIT: begin
				out_d.status = cpr_pkg::STATUS_HIT;
				out_d.slot   = SW'(idx_q);
			end
			cpr_pkg::OP_RESIDENT: begin
				out_d.status = cpr_pkg::STATUS_RESIDENT;
				out_d.slot   = SW'(idx_q);
			end
			cpr_pkg::OP_PLACE: begin
				out_d.status = cpr_pkg::STATUS_PLACED;
				out_d.slot   = SW'(fill_q);
			end
			cpr_pkg::OP_REPLACE: begin
				out_d.status      = cpr_pkg::STATUS_REPLACED;
				out_d.slot        = SW'(ptr_q);
				out_d.victim_page = rd_data_q;
				out_d.writeback   = dirty_q[ptr_q];
			end
			default: begin
				out_d.status = cpr_pkg::STATUS_MISS;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_word <= out_d;
		end
	end

`ifndef SYNTHESIS
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= SLOTS_F)
		else $error("fill count beyond slot count");

	a_scan_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> (FW'(ptr_q) < fill_q))
		else $error("scan pointer outside filled slots");

	a_place_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && cmd.op == cpr_pkg::OP_PLACE) |=> (fill_q == $past(fill_q) + FW'(1)))
		else $error("free placement did not grow the set");
`endif

endmodule

// ===== src/cpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpr_ctrl
// Controller: sequences lookup, victim scan and commit of one word, and
// owns the handshake flags of both channels.
// ----------------------------------------------------------------------------
module cpr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  cpr_pkg::sts_t sts,
	output cpr_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_LOOKUP = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	cpr_pkg::op_t      op_q;
	cpr_pkg::op_t      op_d;
	logic              out_valid_q;

	always_comb begin
		state_d          = state_q;
		op_d             = op_q;
		cmd              = '0;
		cmd.op           = op_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.lookup_start = 1'b1;
					state_d          = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (sts.match) begin
					op_d    = (sts.mode == cpr_pkg::MODE_FAULT) ? cpr_pkg::OP_RESIDENT
						: cpr_pkg::OP_HIT;
					state_d = ST_FINISH;
				end else if (sts.lookup_last) begin
					if (sts.mode == cpr_pkg::MODE_ACCESS) begin
						op_d    = cpr_pkg::OP_MISS;
						state_d = ST_FINISH;
					end else if (sts.can_place) begin
						op_d    = cpr_pkg::OP_PLACE;
						state_d = ST_FINISH;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = ST_SCAN;
					end
				end else begin
					cmd.lookup_next = 1'b1;
				end
			end
			ST_SCAN: begin
				if (sts.victim_found) begin
					op_d    = cpr_pkg::OP_REPLACE;
					state_d = ST_FINISH;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= cpr_pkg::OP_MISS;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_accept_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_LOOKUP))
		else $error("accepted word did not start a lookup");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || !out_stall))
		else $error("commit over an untaken result word");

	a_out_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.commit))
		else $error("result word raised without a commit");
`endif

endmodule

// ===== src/clock_page_replacement.sv =====
// ----------------------------------------------------------------------------
// clock_page_replacement
// Working-set page replacement with a clock hand: resident page lookup,
// free-slot placement and plain or modified clock victim selection.
// ----------------------------------------------------------------------------
// Each word is handled one at a time. After a word is taken the block reads
// the page memory one slot a cycle from slot 0 until the lowest matching
// resident page or the last filled slot. A fault that needs a victim then
// walks the clock hand one slot a cycle. A commit step then updates the state
// and loads the result word once the output register is free or being taken.
// The single read port of the page memory and the single scan pointer set
// this pace. The next word is taken in the cycle after the commit, while the
// result word may still wait in its output register.
module clock_page_replacement #(
	parameter int WS_SLOTS = cpr_pkg::WS_SLOTS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cpr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  cpr_pkg::in_word_t              in_word,
	output logic                           out_valid,
	input  logic                           out_stall,
	output cpr_pkg::out_word_t             out_word
);

	cpr_pkg::cmd_t cmd;
	cpr_pkg::sts_t sts;

	cpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	cpr_dp #(
		.WS_SLOTS (WS_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_word   (in_word),
		.cmd       (cmd),
		.sts       (sts),
		.out_word  (out_word)
	);

endmodule

// ===== bench/tb_clock_page_replacement.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_clock_page_replacement
// Self-checking bench for the clock page replacement block. A behavioral
// copy of the working set (slots, used and modified bits, hand, fill count)
// predicts every result word, which a checker compares field by field with
// the block's output. Directed tests cover small and lowered set sizes and
// both clock variants, then randomized phases run a page pool under changing
// configurations with random gaps on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_clock_page_replacement;
	import cpr_pkg::*;

	localparam int POOL_SIZE   = 24;
	localparam int STUCK_LIMIT = 3000;
	localparam int DRAIN_WAIT  = 70;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	in_word_t              in_word;
	logic                  out_valid;
	logic                  out_stall;
	out_word_t             out_word;

	clock_page_replacement dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	// working set copy
	logic [PAGE_BITS-1:0] ws_page  [WS_SLOTS];
	logic                 ws_valid [WS_SLOTS];
	logic                 ws_used  [WS_SLOTS];
	logic                 ws_dirty [WS_SLOTS];
	int                   ws_hand;
	int                   ws_fill;
	logic                 cur_alg;
	logic [WS_SIZE_W-1:0] cur_size;

	out_word_t            pending_results[$];
	logic [PAGE_BITS-1:0] page_pool[POOL_SIZE];

	bit tx_steady;
	bit rx_steady;
	int rx_hold;
	int mismatches;
	int stuck_cycles;
	int words_sent;
	int n_hit, n_miss, n_place, n_replace, n_writeback, n_resident;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int active_slots();
		if (cur_size == '0)
			return 1;
		if (cur_size > WS_SLOTS)
			return WS_SLOTS;
		return int'(cur_size);
	endfunction

	function automatic int pick_victim(input int ring);
		int s;
		int start;
		int k;
		start = (ws_hand < ring) ? ws_hand : 0;
		while (1) begin
			if (cur_alg == ALG_MODIFIED) begin
				s = start;
				for (k = 0; k < ring; k++) begin
					if (!ws_used[s] && !ws_dirty[s])
						return s;
					s = (s + 1 < ring) ? s + 1 : 0;
				end
			end
			s = start;
			for (k = 0; k < ring; k++) begin
				if (!ws_used[s])
					return s;
				ws_used[s] = 1'b0;
				s = (s + 1 < ring) ? s + 1 : 0;
			end
		end
		return 0;
	endfunction

	function automatic out_word_t predict_word(input in_word_t w);
		out_word_t r;
		int hit;
		int s;
		int ring;
		r = '0;
		hit = -1;
		for (s = 0; s < WS_SLOTS; s++)
			if (hit < 0 && ws_valid[s] && ws_page[s] == w.page_number)
				hit = s;
		if (w.mode == MODE_ACCESS) begin
			if (hit >= 0) begin
				ws_used[hit] = 1'b1;
				if (w.is_write)
					ws_dirty[hit] = 1'b1;
				r.status = STATUS_HIT;
				r.slot = SLOT_W'(hit);
				n_hit++;
			end else begin
				r.status = STATUS_MISS;
				n_miss++;
			end
		end else if (hit >= 0) begin
			r.status = STATUS_RESIDENT;
			r.slot = SLOT_W'(hit);
			n_resident++;
		end else if (ws_fill < active_slots() && ws_fill < WS_SLOTS) begin
			s = ws_fill;
			ws_page[s] = w.page_number;
			ws_valid[s] = 1'b1;
			ws_used[s] = 1'b0;
			ws_dirty[s] = 1'b0;
			ws_fill++;
			r.status = STATUS_PLACED;
			r.slot = SLOT_W'(s);
			n_place++;
		end else begin
			ring = (ws_fill == 0) ? 1 : ws_fill;
			s = pick_victim(ring);
			r.victim_page = ws_page[s];
			r.writeback = ws_dirty[s];
			ws_page[s] = w.page_number;
			ws_valid[s] = 1'b1;
			ws_used[s] = 1'b0;
			ws_dirty[s] = 1'b0;
			ws_hand = (s + 1 < ring) ? s + 1 : 0;
			r.status = STATUS_REPLACED;
			r.slot = SLOT_W'(s);
			n_replace++;
			if (r.writeback)
				n_writeback++;
		end
		return r;
	endfunction

	function automatic in_word_t make_word(input logic mode, input logic [PAGE_BITS-1:0] page,
		input logic wr);
		in_word_t w;
		w.mode = mode;
		w.page_number = page;
		w.is_write = wr;
		return w;
	endfunction

	function automatic in_word_t random_word();
		in_word_t w;
		w.mode = ($urandom_range(0, 99) < 45) ? MODE_FAULT : MODE_ACCESS;
		if ($urandom_range(0, 99) < 88)
			w.page_number = page_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			w.page_number = PAGE_BITS'($urandom);
		w.is_write = 1'($urandom);
		return w;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		if (idx == CFG_ALGORITHM)
			cur_alg = value[0];
		else
			cur_size = value[WS_SIZE_W-1:0];
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_word(input in_word_t w);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		pending_results.push_back(predict_word(w));
		words_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_small_set();
		write_reg(CFG_WS_SIZE, 5'd0);
		send_word(make_word(MODE_ACCESS, 20'h00000, 1'b0));
		send_word(make_word(MODE_FAULT, 20'h00000, 1'b1));
		send_word(make_word(MODE_FAULT, 20'h00000, 1'b0));
		send_word(make_word(MODE_ACCESS, 20'h00000, 1'b1));
		send_word(make_word(MODE_FAULT, 20'hFFFFF, 1'b0));
		send_word(make_word(MODE_ACCESS, 20'hFFFFF, 1'b0));
		send_word(make_word(MODE_FAULT, page_pool[9], 1'b1));
		drain_results();
		write_reg(CFG_WS_SIZE, 5'd1);
		send_word(make_word(MODE_FAULT, 20'h00000, 1'b0));
		drain_results();
	endtask

	task automatic test_modified_clock();
		write_reg(CFG_ALGORITHM, 5'b11111);
		write_reg(CFG_WS_SIZE, 5'd4);
		send_word(make_word(MODE_FAULT, page_pool[0], 1'b0));
		send_word(make_word(MODE_FAULT, page_pool[1], 1'b0));
		send_word(make_word(MODE_FAULT, page_pool[2], 1'b1));
		send_word(make_word(MODE_ACCESS, page_pool[0], 1'b1));
		send_word(make_word(MODE_ACCESS, page_pool[1], 1'b0));
		send_word(make_word(MODE_ACCESS, 20'h00000, 1'b1));
		send_word(make_word(MODE_FAULT, page_pool[3], 1'b0));
		send_word(make_word(MODE_FAULT, page_pool[4], 1'b0));
		send_word(make_word(MODE_FAULT, page_pool[5], 1'b0));
		send_word(make_word(MODE_ACCESS, page_pool[8], 1'b1));
		drain_results();
	endtask

	task automatic test_size_below_fill();
		write_reg(CFG_WS_SIZE, 5'd2);
		write_reg(CFG_ALGORITHM, 5'b11110);
		send_word(make_word(MODE_FAULT, page_pool[6], 1'b0));
		send_word(make_word(MODE_ACCESS, page_pool[6], 1'b1));
		send_word(make_word(MODE_FAULT, page_pool[7], 1'b0));
		send_word(make_word(MODE_FAULT, page_pool[8], 1'b1));
		drain_results();
	endtask

	// receiver holds off while the sender keeps the input busy
	task automatic test_output_backpressure();
		int i;
		tx_steady = 1'b1;
		rx_hold = 300;
		for (i = 0; i < 12; i++)
			send_word(random_word());
		drain_results();
		tx_steady = 1'b0;
	endtask

	task automatic test_random_mix();
		int phase;
		int i;
		logic                 alg_list  [8];
		logic [WS_SIZE_W-1:0] size_list [8];
		alg_list  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
		size_list = '{5'd6, 5'd9, 5'd31, 5'd17, 5'd16, 5'd12, 5'd2, 5'd16};
		for (phase = 0; phase < 8; phase++) begin
			write_reg(CFG_ALGORITHM, {4'($urandom), alg_list[phase]});
			write_reg(CFG_WS_SIZE, size_list[phase]);
			tx_steady = (phase == 3 || phase == 5);
			rx_steady = (phase == 3 || phase == 6);
			for (i = 0; i < 60; i++) begin
				send_word(random_word());
				if (i == 30 && phase[0])
					drain_results();
			end
			drain_results();
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// receiver: random stall before each word, plus an optional long hold
	initial begin
		int hold_len;
		forever begin
			hold_len = rx_hold + (rx_steady ? 0 : $urandom_range(0, 10));
			rx_hold = 0;
			if (hold_len != 0) begin
				out_stall <= 1'b1;
				repeat (hold_len) @(posedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!(out_valid === 1'b1 && out_stall === 1'b0));
		end
	end

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word at %0t: %h", $realtime, out_word);
			end else begin
				want = pending_results.pop_front();
				if (out_word.status !== want.status || out_word.slot !== want.slot ||
					out_word.victim_page !== want.victim_page ||
					out_word.writeback !== want.writeback) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch at %0t (expected/actual): status %0d/%0d ",
							"slot %0d/%0d victim %h/%h writeback %0d/%0d"}, $realtime,
							want.status, out_word.status, want.slot, out_word.slot,
							want.victim_page, out_word.victim_page,
							want.writeback, out_word.writeback);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
			(out_valid === 1'b1 && out_stall === 1'b0) || cfg_we === 1'b1)
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("timeout: no handshake for %0d cycles, %0d results pending",
				STUCK_LIMIT, pending_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int i;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		in_word <= '0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		rx_hold = 0;
		mismatches = 0;
		stuck_cycles = 0;
		words_sent = 0;
		for (i = 0; i < WS_SLOTS; i++) begin
			ws_page[i] = '0;
			ws_valid[i] = 1'b0;
			ws_used[i] = 1'b0;
			ws_dirty[i] = 1'b0;
		end
		ws_hand = 0;
		ws_fill = 0;
		cur_alg = ALG_CLOCK;
		cur_size = WS_SIZE_RST;
		for (i = 0; i < POOL_SIZE; i++)
			page_pool[i] = PAGE_BITS'($urandom);
		page_pool[POOL_SIZE - 2] = '0;
		page_pool[POOL_SIZE - 1] = '1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_small_set();
		test_modified_clock();
		test_size_below_fill();
		test_output_backpressure();
		test_random_mix();

		drain_results();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d words: %0d hits, %0d misses, %0d resident faults, %0d placements",
			words_sent, n_hit, n_miss, n_resident, n_place);
		$display("replacements %0d (%0d with writeback), result mismatches %0d",
			n_replace, n_writeback, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
src/cpr_pkg.sv
src/cpr_dp.sv
src/cpr_ctrl.sv
src/clock_page_replacement.sv
bench/tb_clock_page_replacement.sv
